### rtl/dae_pkg.sv
package dae_pkg;

    // result status codes
    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_BADCLASS = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // header check and record constants
    localparam logic [15:0] QUERY_ID_RESET = 16'hDEAD;
    localparam logic [15:0] HDR_FLAG_MASK  = 16'h800F;
    localparam logic [15:0] HDR_FLAG_VALUE = 16'h8000;
    localparam logic [15:0] CLASS_IN       = 16'd1;
    localparam logic [15:0] TYPE_A         = 16'd1;

    // output beat width: status plus address, padded to whole bytes
    localparam int unsigned RES_BITS  = 34;
    localparam int unsigned TDATA_OUT = 40;

    // parse phases
    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_QNAME  = 6'b000010,
        PH_QTAIL  = 6'b000100,
        PH_ANSHDR = 6'b001000,
        PH_ADDR   = 6'b010000,
        PH_SKIP   = 6'b100000
    } t_phase;

    // one result item
    typedef struct packed {
        logic [31:0] address;
        logic [1:0]  status;
    } t_result;

    // output queue status toward the top level
    typedef struct packed {
        logic       valid;
        logic [1:0] count;
    } t_queue_status;

endpackage

### rtl/dae_parser.sv
module dae_parser
    import dae_pkg::*;
#(
    parameter int unsigned MAX_MESSAGE_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_data,
    input  logic        i_last,
    input  logic [15:0] i_query_id,
    output logic        o_res_valid,
    output t_result     o_res
);

    localparam int unsigned POS_W = $clog2(MAX_MESSAGE_BYTES + 1);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_data;
    logic        r_in_last;

    // parse state
    logic [POS_W-1:0] r_pos,     n_pos;
    t_phase           r_phase,   n_phase;
    logic [15:0]      r_hdr,     n_hdr;
    logic [3:0]       r_fc,      n_fc;
    logic [15:0]      r_type,    n_type;
    logic [15:0]      r_class,   n_class;
    logic [15:0]      r_skip,    n_skip;
    logic [31:0]      r_addr,    n_addr;
    logic             r_decided, n_decided;
    logic [1:0]       r_status,  n_status;

    // capture every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_valid;
        end
        if (i_valid) begin
            r_in_data <= i_data;
            r_in_last <= i_last;
        end
    end

    // per-byte parse step and end-of-message result
    always_comb begin
        n_pos       = r_pos;
        n_phase     = r_phase;
        n_hdr       = r_hdr;
        n_fc        = r_fc;
        n_type      = r_type;
        n_class     = r_class;
        n_skip      = r_skip;
        n_addr      = r_addr;
        n_decided   = r_decided;
        n_status    = r_status;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (r_in_valid) begin
            if (!r_decided) begin
                if (r_pos >= POS_W'(MAX_MESSAGE_BYTES)) begin
                    // overlong message
                    n_decided = 1'b1;
                    n_status  = ST_NOTFOUND;
                end else begin
                    n_pos = r_pos + POS_W'(1);
                    case (r_phase)
                        PH_HEADER: begin
                            n_hdr = {r_hdr[7:0], r_in_data};
                            if (r_pos == POS_W'(1)) begin
                                n_type = n_hdr;
                            end else if (r_pos == POS_W'(3)) begin
                                if (r_type != i_query_id ||
                                    (n_hdr & HDR_FLAG_MASK) != HDR_FLAG_VALUE) begin
                                    n_decided = 1'b1;
                                    n_status  = ST_MISMATCH;
                                end
                            end else if (r_pos == POS_W'(11)) begin
                                n_phase = PH_QNAME;
                                n_type  = '0;
                            end
                        end
                        PH_QNAME: begin
                            if (r_in_data == 8'd0) begin
                                n_phase = PH_QTAIL;
                                n_fc    = '0;
                            end
                        end
                        PH_QTAIL: begin
                            n_fc = r_fc + 4'd1;
                            if (n_fc >= 4'd4) begin
                                n_phase = PH_ANSHDR;
                                n_fc    = '0;
                            end
                        end
                        PH_ANSHDR: begin
                            if (r_fc inside {4'd2, 4'd3}) begin
                                n_type = {r_type[7:0], r_in_data};
                            end else if (r_fc inside {4'd4, 4'd5}) begin
                                n_class = {r_class[7:0], r_in_data};
                            end else if (r_fc inside {4'd10, 4'd11}) begin
                                n_skip = {r_skip[7:0], r_in_data};
                            end
                            if (r_fc == 4'd5 && n_class != CLASS_IN) begin
                                n_decided = 1'b1;
                                n_status  = ST_BADCLASS;
                            end else begin
                                n_fc = r_fc + 4'd1;
                                if (n_fc >= 4'd12) begin
                                    n_fc = '0;
                                    if (n_type == TYPE_A) begin
                                        n_phase = PH_ADDR;
                                        n_addr  = '0;
                                    end else if (n_skip != 16'd0) begin
                                        n_phase = PH_SKIP;
                                    end
                                    n_type  = '0;
                                    n_class = '0;
                                end
                            end
                        end
                        PH_ADDR: begin
                            n_addr = {r_addr[23:0], r_in_data};
                            n_fc   = r_fc + 4'd1;
                            if (n_fc >= 4'd4) begin
                                n_decided = 1'b1;
                                n_status  = ST_FOUND;
                            end
                        end
                        PH_SKIP: begin
                            n_skip = r_skip - 16'd1;
                            if (n_skip == 16'd0) begin
                                n_phase = PH_ANSHDR;
                                n_fc    = '0;
                            end
                        end
                        default: begin
                            n_decided = 1'b1;
                            n_status  = ST_NOTFOUND;
                        end
                    endcase
                end
            end

            // last beat: emit result and re-arm
            if (r_in_last) begin
                o_res_valid    = 1'b1;
                o_res.status   = n_decided ? n_status : ST_NOTFOUND;
                o_res.address  = (n_decided && n_status == ST_FOUND) ? n_addr : 32'd0;
                n_pos     = '0;
                n_phase   = PH_HEADER;
                n_hdr     = '0;
                n_fc      = '0;
                n_type    = '0;
                n_class   = '0;
                n_skip    = '0;
                n_addr    = '0;
                n_decided = 1'b0;
                n_status  = ST_NOTFOUND;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_phase   <= PH_HEADER;
            r_hdr     <= '0;
            r_fc      <= '0;
            r_type    <= '0;
            r_class   <= '0;
            r_skip    <= '0;
            r_addr    <= '0;
            r_decided <= 1'b0;
            r_status  <= ST_NOTFOUND;
        end else begin
            r_pos     <= n_pos;
            r_phase   <= n_phase;
            r_hdr     <= n_hdr;
            r_fc      <= n_fc;
            r_type    <= n_type;
            r_class   <= n_class;
            r_skip    <= n_skip;
            r_addr    <= n_addr;
            r_decided <= n_decided;
            r_status  <= n_status;
        end
    end

endmodule

### rtl/dae_out_queue.sv
module dae_out_queue
    import dae_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_result       i_push_data,
    input  logic          i_ready,
    output t_queue_status o_status,
    output t_result       o_data
);

    // two-entry result buffer
    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_pop;
    logic       w_push;

    assign w_pop  = (r_count != 2'd0) && i_ready;
    assign w_push = i_push && (r_count != 2'd2);

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.valid = (r_count != 2'd0);
    assign o_status.count = r_count;

endmodule

### rtl/dns_answer_address_extractor.sv
// DNS response address extractor
//
// Slave stream: one message byte per beat, i_s_tlast on the final byte.
// Master stream: one result beat per message, status and IPv4 address.
// Config: i_cfg_we writes i_cfg_wdata into the expected transaction ID;
// write only while no message is in progress.
//
// Throughput is one byte per cycle while o_s_tready is high. The byte path is
// an input register, combinational header/question/answer parse logic, and a
// two-entry result queue. o_m_tvalid rises once the last byte of a message has
// passed the input register and its result has been written into the queue.
//
// Reset clears the parser, the result queue and sets the ID to 0xdead.
// When the receiver stalls, o_s_tready drops once the queue plus the result
// still in the parse stage hold two entries and no result beat leaves at
// that edge; it stays low until a result beat is taken.
module dns_answer_address_extractor
    import dae_pkg::*;
#(
    parameter int unsigned MAX_MESSAGE_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // last_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [1:0] status, [33:2] address, [39:34] zero
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    logic [15:0]   r_qid;
    logic          w_accept;
    logic          w_res_valid;
    t_result       w_res;
    t_result       w_out;
    t_queue_status w_qstat;

    // expected transaction ID
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qid <= QUERY_ID_RESET;
        end else if (i_cfg_we) begin
            r_qid <= i_cfg_wdata;
        end
    end

    // room for queued results plus one in the parse stage, or a beat leaving
    assign o_s_tready = i_m_tready ||
                        (({1'b0, w_qstat.count} + {2'b00, w_res_valid}) < 3'd2);
    assign w_accept   = i_s_tvalid && o_s_tready;

    dae_parser #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_data      (i_s_tdata),
        .i_last      (i_s_tlast),
        .i_query_id  (r_qid),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    dae_out_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_res_valid),
        .i_push_data (w_res),
        .i_ready     (i_m_tready),
        .o_status    (w_qstat),
        .o_data      (w_out)
    );

    // result beat packing
    assign o_m_tvalid = w_qstat.valid;
    assign o_m_tdata  = {{(TDATA_OUT - RES_BITS){1'b0}}, w_out.address, w_out.status};

endmodule

### rtl/dae_checker.sv
module dae_checker
    import dae_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat dropped or changed while stalled");

    // address is zero unless found
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1:0] != ST_FOUND |-> o_m_tdata[33:2] == 32'd0)
        else $error("address set on a result that was not found");

    // padding bits stay clear
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[39:34] == 6'd0)
        else $error("padding bits of result beat not zero");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // a result that rises after an empty queue needs an accepted last byte before it
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid ##1 !o_m_tvalid ##1 o_m_tvalid |->
            $past(i_s_tvalid && o_s_tready && i_s_tlast, 2))
        else $error("result beat without a last byte");

endmodule

bind dns_answer_address_extractor dae_checker u_dae_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .i_s_tlast   (i_s_tlast),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata)
);
